>>> rtl/core/lfu_pkg.sv
package lfu_pkg;

    localparam int unsigned NumEntries = 64;
    localparam int unsigned IdxW       = $clog2(NumEntries);
    localparam int unsigned CntW       = 32;
    localparam int unsigned CfgW       = 7;
    // The row of cells is cut into segments with a register between them.
    localparam int unsigned SegCells   = 4;
    localparam int unsigned NumSegs    = NumEntries / SegCells;
    localparam int unsigned SegW       = $clog2(NumSegs);

    localparam logic       CmdGet = 1'b0;
    localparam logic       CmdPut = 1'b1;
    localparam logic [1:0] RegMaxEntries = 2'd0;

    // Operation broadcast to every cell for one word.
    typedef enum logic [3:0] {
        OP_NONE   = 4'b0001,
        OP_TOUCH  = 4'b0010,
        OP_REMOVE = 4'b0100,
        OP_INSERT = 4'b1000
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IdxW-1:0]  slot;
        logic [IdxW-1:0]  rank;
        logic             wr_data;
        logic [31:0]      key;
        logic [31:0]      data;
    } t_cell_cmd;

    // Candidate handed along the chain: best hit and best victim so far.
    typedef struct packed {
        logic             hit;
        logic [IdxW-1:0]  hit_idx;
        logic [31:0]      hit_data;
        logic [IdxW-1:0]  hit_rank;
        logic             vic;
        logic [IdxW-1:0]  vic_idx;
        logic [CntW-1:0]  vic_cnt;
        logic [IdxW-1:0]  vic_rank;
        logic             free;
        logic [IdxW-1:0]  free_idx;
    } t_chain;

endpackage

>>> rtl/core/lfu_cell.sv
module lfu_cell
    import lfu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [IdxW-1:0] i_idx,
    input  logic [31:0]     i_lookup_key,
    input  t_cell_cmd       i_cmd,
    input  t_chain          i_chain,
    output t_chain          o_chain
);

    logic            r_valid;
    logic [31:0]     r_key;
    logic [31:0]     r_data;
    logic [CntW-1:0] r_cnt;
    logic [IdxW-1:0] r_rank;
    logic            mine;
    logic            better;

    assign mine = (i_cmd.slot == i_idx);

    // Victim order: lowest count, then the oldest rank.
    assign better = !i_chain.vic || (r_cnt < i_chain.vic_cnt)
                  || ((r_cnt == i_chain.vic_cnt) && (r_rank > i_chain.vic_rank));

    always_comb begin
        o_chain = i_chain;
        if (r_valid && !i_chain.hit && r_key == i_lookup_key) begin
            o_chain.hit      = 1'b1;
            o_chain.hit_idx  = i_idx;
            o_chain.hit_data = r_data;
            o_chain.hit_rank = r_rank;
        end
        if (r_valid && better) begin
            o_chain.vic      = 1'b1;
            o_chain.vic_idx  = i_idx;
            o_chain.vic_cnt  = r_cnt;
            o_chain.vic_rank = r_rank;
        end
        if (!r_valid && !i_chain.free) begin
            o_chain.free     = 1'b1;
            o_chain.free_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_TOUCH: begin
                    if (mine) begin
                        r_rank <= '0;
                        if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
                        if (i_cmd.wr_data) r_data <= i_cmd.data;
                    end else if (r_valid && r_rank < i_cmd.rank) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (mine) r_valid <= 1'b0;
                    else if (r_valid && r_rank > i_cmd.rank) r_rank <= r_rank - 1'b1;
                end
                OP_INSERT: begin
                    if (mine) begin
                        r_valid <= 1'b1;
                        r_key   <= i_cmd.key;
                        r_data  <= i_cmd.data;
                        r_cnt   <= CntW'(1);
                        r_rank  <= '0;
                    end else if (r_valid) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/lfu_cache_with_lru_tiebreak_unit.sv
// LFU cache with LRU tie-break. Up to 64 key/value entries sit in a row of
// cells; each cell compares its key, keeps its use count and recency rank, and
// passes the best hit, the best eviction candidate and the first free slot on
// to its neighbour. The row is cut into 16 segments of four cells with a
// register between neighbouring segments, so one scan of the row steps
// through the segments in turn and no clock path runs through more than four
// cells. A word is accepted only when the block is idle; after acceptance it
// scans the row and then updates it, and its result word appears after the
// update. A put of a new key into a full cache first removes its victim in
// an eviction state. The result word then sits in an output register until
// taken, and the next word can be accepted at the edge that takes it, so the
// block takes no new word while a result waits. Register 0 (max_entries,
// address 0) sets the capacity; values above 64 act as 64, zero makes puts
// change nothing.
module lfu_cache_with_lru_tiebreak_unit
    import lfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [31:0] i_lookup_key,
    input  logic [31:0] i_store_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [31:0] o_read_value,
    output logic        o_evicted,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_EVICT  = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    t_state          r_state;
    logic [CfgW-1:0] r_max;
    logic            r_cmd;
    logic [31:0]     r_key, r_val;
    logic [IdxW:0]   r_occ;
    logic [SegW-1:0] r_seg_cnt;
    t_chain          r_scan;
    logic            r_ovalid, r_found, r_evicted;
    logic [31:0]     r_read;
    t_cell_cmd       cmd;
    t_chain          chain [NumEntries];
    t_chain          chain_out [NumEntries];
    t_chain          scan_out;
    logic [IdxW:0]   cap;
    logic            accept;

    assign pready = 1'b1;
    assign prdata = (paddr == RegMaxEntries) ? {25'd0, r_max} : 32'd0;
    assign cap    = (r_max > CfgW'(NumEntries)) ? (IdxW+1)'(NumEntries)
                                                 : r_max[IdxW:0];
    assign o_stall = !(r_state == ST_IDLE) || (r_ovalid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_found = r_found;
    assign o_read_value = r_read;
    assign o_evicted = r_evicted;

    assign chain[0] = '0;
    for (genvar g = 0; g < NumEntries; g++) begin : g_cell
        lfu_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_idx        (IdxW'(g)),
            .i_lookup_key (r_key),
            .i_cmd        (cmd),
            .i_chain      (chain[g]),
            .o_chain      (chain_out[g])
        );
    end

    // Inside a segment the candidate passes straight on to the next cell.
    for (genvar g = 1; g < NumEntries; g++) begin : g_wire
        if (g % SegCells != 0) begin : g_pass
            assign chain[g] = chain_out[g-1];
        end
    end

    // Between segments it is registered. The cells and the key hold still for
    // the whole scan, so the last segment has settled when the scan ends.
    for (genvar s = 1; s < NumSegs; s++) begin : g_link
        t_chain r_link;
        always_ff @(posedge i_clk) begin
            r_link <= chain_out[s*SegCells-1];
        end
        assign chain[s*SegCells] = r_link;
    end

    assign scan_out = chain_out[NumEntries-1];

    // Command to the row, worked out from the registered scan.
    always_comb begin
        cmd         = '0;
        cmd.op      = OP_NONE;
        cmd.key     = r_key;
        cmd.data    = r_val;
        if (r_state == ST_EVICT) begin
            cmd.op   = OP_REMOVE;
            cmd.slot = r_scan.vic_idx;
            cmd.rank = r_scan.vic_rank;
        end else if (r_state == ST_UPDATE) begin
            if (r_scan.hit && (r_cmd == CmdGet || cap != '0)) begin
                cmd.op      = OP_TOUCH;
                cmd.slot    = r_scan.hit_idx;
                cmd.rank    = r_scan.hit_rank;
                cmd.wr_data = (r_cmd == CmdPut);
            end else if (r_cmd == CmdPut && cap != '0 && !r_scan.hit) begin
                cmd.op   = OP_INSERT;
                // After a removal the first free slot is the lower of the slot
                // just emptied and the first one that was free before it.
                if (r_evicted && !(r_scan.free && r_scan.free_idx < r_scan.vic_idx))
                    cmd.slot = r_scan.vic_idx;
                else
                    cmd.slot = r_scan.free_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_max     <= CfgW'(NumEntries);
            r_occ     <= '0;
            r_ovalid  <= 1'b0;
            r_seg_cnt <= '0;
        end else begin
            if (psel && penable && pwrite && paddr == RegMaxEntries)
                r_max <= pwdata[CfgW-1:0];
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_seg_cnt <= '0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_seg_cnt == SegW'(NumSegs-1)) begin
                        r_scan    <= scan_out;
                        r_found   <= scan_out.hit;
                        r_evicted <= 1'b0;
                        if (r_cmd == CmdPut && cap != '0 && !scan_out.hit
                            && r_occ >= cap && scan_out.vic) begin
                            r_state <= ST_EVICT;
                        end else begin
                            r_state <= ST_UPDATE;
                        end
                    end else begin
                        r_seg_cnt <= r_seg_cnt + 1'b1;
                    end
                end
                ST_EVICT: begin
                    r_evicted <= 1'b1;
                    r_occ     <= r_occ - 1'b1;
                    r_state   <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (cmd.op == OP_INSERT) r_occ <= r_occ + 1'b1;
                    r_read   <= (r_cmd == CmdPut) ? 32'd0
                              : (r_scan.hit ? r_scan.hit_data : 32'hFFFF_FFFF);
                    r_ovalid <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_key <= i_lookup_key;
            r_val <= i_store_value;
        end
    end

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= (IdxW+1)'(NumEntries)) else $error("occupancy overflow");
    a_evict_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EVICT |-> r_cmd == CmdPut) else $error("evict on get");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPDATE |=> r_ovalid) else $error("result lost");

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

// Testbench for the LFU cache with LRU tie-break. A behavioural copy of the
// cache (per-entry valid, key, data, use count and recency rank) predicts the
// answer to every accepted request word; a monitor compares each result word
// against the oldest prediction, field by field.
module tb;
    import lfu_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_command;
    logic [31:0] i_lookup_key;
    logic [31:0] i_store_value;
    logic        o_valid;
    logic        i_stall;
    logic        o_found;
    logic [31:0] o_read_value;
    logic        o_evicted;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lfu_cache_with_lru_tiebreak_unit dut (.*);

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        evicted;
    } t_answer;

    // Model of the cache contents.
    logic        mdl_valid [NumEntries];
    logic [31:0] mdl_key   [NumEntries];
    logic [31:0] mdl_data  [NumEntries];
    logic [31:0] mdl_count [NumEntries];
    logic [31:0] mdl_rank  [NumEntries];
    int unsigned mdl_occupied;
    logic [CfgW-1:0] mdl_capacity_reg;

    t_answer answers_due[$];
    int      mismatches;
    longint  cycle_count;
    int      words_checked;
    int      evictions_seen;
    int      hits_seen;
    logic    sink_hold;     // long receiver hold-off in progress
    int      sink_gap_max;  // 0 disables random stalling of results

    localparam longint CycleLimit = 2000000;

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Move an entry to most recent and bump its saturating use count.
    function automatic void touch_entry(input int slot);
        logic [31:0] r;
        r = mdl_rank[slot];
        for (int j = 0; j < NumEntries; j++)
            if (mdl_valid[j] && mdl_rank[j] < r) mdl_rank[j]++;
        mdl_rank[slot] = 0;
        if (mdl_count[slot] != 32'hFFFF_FFFF) mdl_count[slot]++;
    endfunction

    // Work out the answer to one request and update the model.
    function automatic t_answer predict_answer(logic cmd, logic [31:0] key,
                                               logic [31:0] val);
        t_answer     a;
        int          slot;
        int          victim;
        int unsigned cap;
        logic [31:0] r;
        cap = (mdl_capacity_reg > NumEntries) ? NumEntries : mdl_capacity_reg;
        slot = -1;
        for (int i = 0; i < NumEntries; i++)
            if (slot < 0 && mdl_valid[i] && mdl_key[i] == key) slot = i;
        a.found = (slot >= 0);
        a.read_value = 32'd0;
        a.evicted = 1'b0;
        if (cmd == CmdGet) begin
            if (slot >= 0) begin
                touch_entry(slot);
                a.read_value = mdl_data[slot];
            end else begin
                a.read_value = 32'hFFFF_FFFF;
            end
        end else if (cap > 0) begin
            if (slot >= 0) begin
                mdl_data[slot] = val;
                touch_entry(slot);
            end else begin
                if (mdl_occupied >= cap) begin
                    victim = -1;
                    for (int j = 0; j < NumEntries; j++) begin
                        if (mdl_valid[j] && (victim < 0 || mdl_count[j] < mdl_count[victim]
                            || (mdl_count[j] == mdl_count[victim]
                                && mdl_rank[j] > mdl_rank[victim])))
                            victim = j;
                    end
                    if (victim >= 0) begin
                        r = mdl_rank[victim];
                        mdl_valid[victim] = 1'b0;
                        for (int j = 0; j < NumEntries; j++)
                            if (mdl_valid[j] && mdl_rank[j] > r) mdl_rank[j]--;
                        if (mdl_occupied > 0) mdl_occupied--;
                        a.evicted = 1'b1;
                    end
                end
                slot = -1;
                for (int j = 0; j < NumEntries; j++)
                    if (slot < 0 && !mdl_valid[j]) slot = j;
                if (slot >= 0) begin
                    for (int j = 0; j < NumEntries; j++)
                        if (mdl_valid[j]) mdl_rank[j]++;
                    mdl_valid[slot] = 1'b1;
                    mdl_key[slot] = key;
                    mdl_data[slot] = val;
                    mdl_count[slot] = 1;
                    mdl_rank[slot] = 0;
                    mdl_occupied++;
                end
            end
        end
        return a;
    endfunction

    // Random gap: mostly short, now and then long.
    function automatic int pick_gap(int longest);
        if (longest == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, longest);
        return $urandom_range(0, 2);
    endfunction

    // Send one request word; the expectation is recorded at acceptance.
    // Called at a falling edge; valid stays high into the next word when
    // there is no gap, and drain drops it at the end of a burst.
    task automatic send_request(input logic cmd, input logic [31:0] key,
                                input logic [31:0] val, input int gap_max);
        int gap;
        gap = pick_gap(gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_lookup_key <= key;
        i_store_value <= val;
        do @(posedge i_clk); while (o_stall);
        answers_due.push_back(predict_answer(cmd, key, val));
        @(negedge i_clk);
    endtask

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                $error("Result word with no request outstanding");
                mismatches++;
            end else begin
                exp_a = answers_due.pop_front();
                words_checked++;
                if (o_found) hits_seen++;
                if (o_evicted) evictions_seen++;
                if (o_found !== exp_a.found) begin
                    $error("found: expected %0b, got %0b", exp_a.found, o_found);
                    mismatches++;
                end
                if (o_read_value !== exp_a.read_value) begin
                    $error("read_value: expected %h, got %h", exp_a.read_value,
                           o_read_value);
                    mismatches++;
                end
                if (o_evicted !== exp_a.evicted) begin
                    $error("evicted: expected %0b, got %0b", exp_a.evicted, o_evicted);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (sink_hold) i_stall <= 1'b1;
        else if (sink_gap_max == 0) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 3) == 0);
    end

    // APB write: setup then access phase.
    task automatic write_capacity(input logic [CfgW-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= RegMaxEntries;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mdl_capacity_reg = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stop offering, wait for every outstanding result, then let it settle.
    task automatic drain;
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_directed;
        write_capacity(7'd2);
        send_request(CmdGet, 32'h8000_0000, 32'h0, 0);          // miss
        send_request(CmdPut, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_request(CmdPut, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_request(CmdGet, 32'h8000_0000, 32'hFFFF_FFFF, 0);  // hit, count 2
        send_request(CmdPut, 32'hFFFF_FFFF, 32'h1234_5678, 0);  // evicts one entry
        send_request(CmdGet, 32'h7FFF_FFFF, 32'h0, 0);
        send_request(CmdPut, 32'h8000_0000, 32'hFFFF_FFFF, 0);  // update in place
        send_request(CmdGet, 32'hFFFF_FFFF, 32'h0, 0);
        send_request(CmdPut, 32'h0, 32'h0, 0);                  // equal counts: LRU goes
        send_request(CmdGet, 32'h0, 32'h0, 0);
        drain();
        // Zero capacity: puts change nothing but gets still hit.
        write_capacity(7'd0);
        send_request(CmdPut, 32'h0, 32'h5555_AAAA, 0);
        send_request(CmdPut, 32'h0000_0042, 32'h1, 0);
        send_request(CmdGet, 32'h0, 32'h0, 0);
        send_request(CmdGet, 32'h0000_0042, 32'h0, 0);
        drain();
        // Capacity above the row size acts as the full row.
        write_capacity(7'd127);
        for (int k = 0; k < 6; k++)
            send_request(CmdPut, 32'(k + 100), 32'(k), 0);
        drain();
        // Capacity lowered below occupancy: each new put evicts one.
        write_capacity(7'd1);
        send_request(CmdPut, 32'hAAAA_5555, 32'h1, 0);
        send_request(CmdGet, 32'(100), 32'h0, 0);
        drain();
    endtask

    // Random traffic on a small key set so hits and evictions are frequent.
    task automatic test_random(input int words, input int key_span);
        logic [31:0] key;
        for (int n = 0; n < words; n++) begin
            if ($urandom_range(0, 19) == 0) key = $urandom();
            else key = 32'($urandom_range(0, key_span)) ^ 32'hF000_0000;
            send_request(logic'($urandom_range(0, 1)), key, $urandom(), 12);
        end
    endtask

    // Sender keeps offering while the receiver holds off for a long stretch.
    task automatic test_backpressure;
        fork
            begin
                sink_hold = 1'b1;
                repeat (200) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            test_random(40, 20);
        join
    endtask

    // Drive a use count towards saturation is infeasible; instead exercise
    // repeated gets of a key not yet stored, then puts that force evictions.
    task automatic test_hot_entries;
        write_capacity(7'd3);
        for (int n = 0; n < 200; n++)
            send_request(CmdGet, 32'h1, 32'h0, 0);
        send_request(CmdPut, 32'h1, 32'h11, 0);
        send_request(CmdPut, 32'h2, 32'h22, 0);
        send_request(CmdPut, 32'h3, 32'h33, 0);
        for (int n = 0; n < 60; n++)
            send_request(CmdPut, 32'(n + 10), $urandom(), 3);
        send_request(CmdGet, 32'h1, 32'h0, 0);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = 1'b0;
        i_lookup_key = '0;
        i_store_value = '0;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        cycle_count = 0;
        words_checked = 0;
        evictions_seen = 0;
        hits_seen = 0;
        sink_hold = 1'b0;
        sink_gap_max = 0;
        mdl_occupied = 0;
        mdl_capacity_reg = 7'd64;
        for (int i = 0; i < NumEntries; i++) begin
            mdl_valid[i] = 1'b0;
            mdl_key[i] = '0;
            mdl_data[i] = '0;
            mdl_count[i] = '0;
            mdl_rank[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // Default capacity first, before any register write.
        test_random(150, 90);
        drain();
        test_directed();
        sink_gap_max = 1;
        test_hot_entries();
        write_capacity(7'd8);
        test_backpressure();
        test_random(400, 16);
        drain();
        write_capacity(7'd64);
        test_random(500, 100);
        drain();
        write_capacity(7'd5);
        test_random(400, 12);
        drain();
        write_capacity(7'd0);
        test_random(100, 12);
        drain();
        write_capacity(7'd33);
        sink_gap_max = 0;
        test_random(300, 50);
        drain();
        $display("Checked %0d result words: %0d hits, %0d evictions.", words_checked,
                 hits_seen, evictions_seen);
        $display("Capacities 0, 1, 2, 3, 5, 8, 33, 64 and 127 were used.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
